[hdl/archive_packet_deframer_assert.svh]
// Assertion macros for the deframer checker.
`ifndef ARCHIVE_PACKET_DEFRAMER_ASSERT_SVH
`define ARCHIVE_PACKET_DEFRAMER_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define APD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deframer check failed");

// Clocked check that also holds through reset.
`define APD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("deframer reset check failed");

`endif

[hdl/apd_pkg.sv]
package apd_pkg;

    localparam int NUM_CHANNELS  = 9;
    localparam int TRAILER_BYTES = 4;
    localparam int FIXED_HEADER  = 10;
    localparam int HEADER_BYTES  = FIXED_HEADER + NUM_CHANNELS * 2;
    localparam int HIDX_W        = $clog2(HEADER_BYTES);
    localparam int CHAN_W        = $clog2(NUM_CHANNELS + 1);

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd2400;
    localparam logic [7:0]  HASH_CHAR        = 8'h23;
    localparam logic [31:0] HASH_TRAILER     = {4{HASH_CHAR}};

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'd1;

    typedef enum logic [1:0] {
        EV_BYTE     = 2'd0,
        EV_HEADER   = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_TRUNC    = 2'd3
    } event_t;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_word_t;

    typedef struct packed {
        event_t              event_res;
        logic                payload_valid;
        logic [7:0]          payload_byte;
        logic [CHAN_W-1:0]   channel;
        logic [7:0]          dest_unit;
        logic [7:0]          packet_type;
        logic [7:0]          sender_unit;
        logic [7:0]          modulus;
        logic [15:0]         data_length;
        logic [31:0]         origin_time;
        logic                bad_packet;
        logic                hash_found;
    } out_word_t;

endpackage

[hdl/archive_packet_deframer.sv]
// Channel  Direction  Handshake          Word
// s_       in         s_valid/s_ready    in_word_t  (data_byte, stream_end)
// m_       out        m_valid/m_ready    out_word_t (event and header fields)
// cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// One word in, one word out; a word is accepted every cycle while the output
// register is empty or being drained, so throughput is one byte per clock.
// The packet state and the result register update on the same edge. Reset is
// synchronous; it clears the packet state, config and m_valid, not m_data.
// A stall on m_ holds the result and s_ready drops until it is taken.
module archive_packet_deframer
    import apd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [15:0]       max_length_reg;
    logic              big_endian_reg;

    phase_t            phase_reg, phase_next;
    logic [HIDX_W-1:0] hidx_reg, hidx_next;
    logic [7:0]        hb_reg [FIXED_HEADER];
    logic [7:0]        hb_next [FIXED_HEADER];
    logic [7:0]        hb_upd [FIXED_HEADER];
    logic [15:0]       ends_reg [NUM_CHANNELS];
    logic [15:0]       ends_next [NUM_CHANNELS];
    logic [15:0]       run_sum_reg, run_sum_next;
    logic [7:0]        cnt_low_reg, cnt_low_next;
    logic [16:0]       offset_reg, offset_next;
    logic              bad_reg, bad_next;
    logic [31:0]       last4_reg, last4_next;

    logic              m_valid_reg;
    out_word_t         m_data_reg;
    out_word_t         res;

    logic              s_accept;
    logic [7:0]        b;
    logic [HIDX_W-1:0] rel;
    logic [15:0]       cnt;
    logic [15:0]       sum_new;
    logic [15:0]       len;
    logic [31:0]       origin;
    logic [16:0]       len_end;
    logic              bad_calc;
    logic              do_clear;
    logic [CHAN_W-1:0] chan;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign b        = s_data.data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
            big_endian_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                CFG_BIG_ENDIAN: big_endian_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Header bytes as they stand after this word, for the header fields in each result.
    always_comb begin
        hb_upd = hb_reg;
        if (phase_reg == PH_HEADER && hidx_reg < HIDX_W'(FIXED_HEADER)) begin
            hb_upd[hidx_reg[3:0]] = b;
        end
    end

    assign len     = big_endian_reg ? {hb_upd[4], hb_upd[5]} : {hb_upd[5], hb_upd[4]};
    assign origin  = big_endian_reg ? {hb_upd[6], hb_upd[7], hb_upd[8], hb_upd[9]}
                                    : {hb_upd[9], hb_upd[8], hb_upd[7], hb_upd[6]};
    assign rel     = hidx_reg - HIDX_W'(FIXED_HEADER);
    assign cnt     = big_endian_reg ? {cnt_low_reg, b} : {b, cnt_low_reg};
    assign sum_new = run_sum_reg + cnt;
    assign len_end = {1'b0, len} + 17'(TRAILER_BYTES);
    assign bad_calc = (len > max_length_reg) || (len != sum_new);

    // First channel whose end offset lies beyond this payload byte.
    always_comb begin
        chan = CHAN_W'(NUM_CHANNELS);
        for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
            if (offset_reg[15:0] < ends_reg[c]) begin
                chan = CHAN_W'(c);
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        hidx_next    = hidx_reg;
        hb_next      = hb_upd;
        ends_next    = ends_reg;
        run_sum_next = run_sum_reg;
        cnt_low_next = cnt_low_reg;
        offset_next  = offset_reg;
        bad_next     = bad_reg;
        last4_next   = last4_reg;
        do_clear     = 1'b0;
        res          = '0;
        res.event_res = EV_BYTE;

        case (phase_reg)
            PH_HEADER: begin
                if (hidx_reg >= HIDX_W'(FIXED_HEADER)) begin
                    if (!rel[0]) begin
                        cnt_low_next = b;
                    end else begin
                        run_sum_next = sum_new;
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (rel[HIDX_W-1:1] == (HIDX_W-1)'(i)) begin
                                ends_next[i] = sum_new;
                            end
                        end
                    end
                end
                if (hidx_reg == HIDX_W'(HEADER_BYTES - 1) || s_data.stream_end) begin
                    res.dest_unit   = hb_upd[0];
                    res.packet_type = hb_upd[1];
                    res.sender_unit = hb_upd[2];
                    res.modulus     = hb_upd[3];
                    res.data_length = len;
                    res.origin_time = origin;
                end
                if (hidx_reg == HIDX_W'(HEADER_BYTES - 1)) begin
                    res.bad_packet = bad_calc;
                    if (s_data.stream_end) begin
                        res.event_res = EV_TRUNC;
                        do_clear      = 1'b1;
                    end else begin
                        res.event_res = EV_HEADER;
                        phase_next    = PH_BODY;
                        offset_next   = '0;
                        last4_next    = '0;
                        bad_next      = bad_calc;
                    end
                end else begin
                    hidx_next = hidx_reg + 1'b1;
                    if (s_data.stream_end) begin
                        res.event_res = EV_TRUNC;
                        do_clear      = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (offset_reg < {1'b0, len}) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = b;
                    res.channel       = chan;
                end
                last4_next      = {last4_reg[23:0], b};
                offset_next     = offset_reg + 1'b1;
                res.dest_unit   = hb_upd[0];
                res.packet_type = hb_upd[1];
                res.sender_unit = hb_upd[2];
                res.modulus     = hb_upd[3];
                res.data_length = len;
                res.origin_time = origin;
                res.bad_packet  = bad_reg;
                if (offset_next >= len_end) begin
                    res.event_res  = EV_COMPLETE;
                    res.hash_found = (last4_next == HASH_TRAILER);
                    do_clear       = 1'b1;
                end else if (s_data.stream_end) begin
                    res.event_res = EV_TRUNC;
                    do_clear      = 1'b1;
                end
            end
            default: ;
        endcase

        // Drop all packet state and start over on the next header.
        if (do_clear) begin
            phase_next   = PH_HEADER;
            hidx_next    = '0;
            for (int i = 0; i < FIXED_HEADER; i++) hb_next[i] = '0;
            for (int i = 0; i < NUM_CHANNELS; i++) ends_next[i] = '0;
            run_sum_next = '0;
            cnt_low_next = '0;
            offset_next  = '0;
            bad_next     = 1'b0;
            last4_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hidx_reg    <= '0;
            for (int i = 0; i < FIXED_HEADER; i++) hb_reg[i] <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) ends_reg[i] <= '0;
            run_sum_reg <= '0;
            cnt_low_reg <= '0;
            offset_reg  <= '0;
            bad_reg     <= 1'b0;
            last4_reg   <= '0;
        end else if (s_accept) begin
            phase_reg   <= phase_next;
            hidx_reg    <= hidx_next;
            hb_reg      <= hb_next;
            ends_reg    <= ends_next;
            run_sum_reg <= run_sum_next;
            cnt_low_reg <= cnt_low_next;
            offset_reg  <= offset_next;
            bad_reg     <= bad_next;
            last4_reg   <= last4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= res;
        end
    end

endmodule

[hdl/apd_checker.sv]
`include "archive_packet_deframer_assert.svh"

module apd_checker
    import apd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_word_t             m_data
);

    logic idle_zero;

    assign idle_zero = (m_data.payload_byte == 8'd0) && (m_data.channel == '0);

    `APD_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `APD_ASSERT(a_word_out, s_valid && s_ready |=> m_valid)
    `APD_ASSERT(a_idle_payload, m_valid && !m_data.payload_valid |-> idle_zero)
    `APD_ASSERT(a_hash_on_done, m_valid && m_data.hash_found |-> m_data.event_res == EV_COMPLETE)
    `APD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind archive_packet_deframer apd_checker u_apd_checker (.*);

[dv/archive_packet_deframer_checker.sv]
`timescale 1ns / 1ps
// Watches the byte and result channels, deframes each accepted byte in step
// with the block and compares every result word against the oldest prediction.
module archive_packet_deframer_checker
    import apd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    // register copies
    logic [15:0] max_len_q;
    logic        be_q;

    // packet state
    phase_t      ph;
    int unsigned hdr_pos;
    logic [7:0]  hdr [FIXED_HEADER];
    logic [15:0] chan_end [NUM_CHANNELS];
    logic [7:0]  cnt_first;
    logic [16:0] body_pos;
    logic        bad_q;
    logic [31:0] tail_q;

    out_word_t   expected_words [$];

    initial begin
        fail_count = 0;
    end

    function automatic void clear_packet_state();
        ph        = PH_HEADER;
        hdr_pos   = 0;
        foreach (hdr[i]) hdr[i] = 8'd0;
        foreach (chan_end[i]) chan_end[i] = 16'd0;
        cnt_first = 8'd0;
        body_pos  = 17'd0;
        bad_q     = 1'b0;
        tail_q    = 32'd0;
    endfunction

    function automatic logic [31:0] hdr_field(int first, int n);
        logic [31:0] v;
        v = 32'd0;
        for (int i = 0; i < n; i++)
            v = (v << 8) | hdr[be_q ? first + i : first + n - 1 - i];
        return v;
    endfunction

    function automatic void fill_header(ref out_word_t o);
        o.dest_unit   = hdr[0];
        o.packet_type = hdr[1];
        o.sender_unit = hdr[2];
        o.modulus     = hdr[3];
        o.data_length = hdr_field(4, 2);
        o.origin_time = hdr_field(6, 4);
    endfunction

    function automatic logic [CHAN_W-1:0] channel_of(logic [16:0] off);
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (off < chan_end[c])
                return CHAN_W'(c);
        return CHAN_W'(NUM_CHANNELS);
    endfunction

    function automatic out_word_t deframe_byte(in_word_t w);
        out_word_t   o;
        int unsigned pos;
        int unsigned rel;
        int unsigned k;
        logic [15:0] cnt;
        logic [15:0] prev;
        logic [15:0] len;
        o = out_word_t'(0);
        if (ph == PH_HEADER) begin
            pos = (hdr_pos >= HEADER_BYTES) ? HEADER_BYTES - 1 : hdr_pos;
            if (pos < FIXED_HEADER) begin
                hdr[pos] = w.data_byte;
            end else begin
                rel = pos - FIXED_HEADER;
                k   = rel >> 1;
                if (rel[0] == 1'b0) begin
                    cnt_first = w.data_byte;
                end else begin
                    cnt  = be_q ? {cnt_first, w.data_byte} : {w.data_byte, cnt_first};
                    prev = (k != 0) ? chan_end[k - 1] : 16'd0;
                    // running end offsets wrap at 16 bits
                    chan_end[k] = prev + cnt;
                end
            end
            if (pos == HEADER_BYTES - 1) begin
                len   = hdr_field(4, 2);
                bad_q = (len > max_len_q) || (len != chan_end[NUM_CHANNELS - 1]);
                fill_header(o);
                o.bad_packet = bad_q;
                if (w.stream_end) begin
                    o.event_res = EV_TRUNC;
                    clear_packet_state();
                end else begin
                    o.event_res = EV_HEADER;
                    ph       = PH_BODY;
                    body_pos = 17'd0;
                    tail_q   = 32'd0;
                end
            end else begin
                hdr_pos = pos + 1;
                if (w.stream_end) begin
                    o.event_res = EV_TRUNC;
                    fill_header(o);
                    clear_packet_state();
                end
            end
            return o;
        end

        len = hdr_field(4, 2);
        if (body_pos < len) begin
            o.payload_valid = 1'b1;
            o.payload_byte  = w.data_byte;
            o.channel       = channel_of(body_pos);
        end
        tail_q   = {tail_q[23:0], w.data_byte};
        body_pos = body_pos + 17'd1;
        fill_header(o);
        o.bad_packet = bad_q;
        if (int'(body_pos) >= int'(len) + TRAILER_BYTES) begin
            o.event_res  = EV_COMPLETE;
            o.hash_found = (tail_q == HASH_TRAILER);
            clear_packet_state();
        end else if (w.stream_end) begin
            o.event_res = EV_TRUNC;
            clear_packet_state();
        end
        return o;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_word(out_word_t want, out_word_t got);
        check_field("event_res", want.event_res, got.event_res);
        check_field("payload_valid", want.payload_valid, got.payload_valid);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("channel", want.channel, got.channel);
        check_field("dest_unit", want.dest_unit, got.dest_unit);
        check_field("packet_type", want.packet_type, got.packet_type);
        check_field("sender_unit", want.sender_unit, got.sender_unit);
        check_field("modulus", want.modulus, got.modulus);
        check_field("data_length", want.data_length, got.data_length);
        check_field("origin_time", want.origin_time, got.origin_time);
        check_field("bad_packet", want.bad_packet, got.bad_packet);
        check_field("hash_found", want.hash_found, got.hash_found);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_len_q = MAX_LENGTH_RESET;
            be_q      = 1'b1;
            clear_packet_state();
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MAX_LENGTH)
                    max_len_q = cfg_wdata;
                else if (cfg_index == CFG_BIG_ENDIAN)
                    be_q = cfg_wdata[0];
            end
            if (s_valid && s_ready)
                expected_words.push_back(deframe_byte(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word expected none got %p", $time, m_data);
                    fail_count++;
                end else begin
                    compare_word(expected_words.pop_front(), m_data);
                end
            end
        end
        pending <= expected_words.size();
    end

endmodule

[dv/archive_packet_deframer_tb.sv]
`timescale 1ns / 1ps
module archive_packet_deframer_tb;
    import apd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int PHASE_WORDS  = 250;

    typedef enum int {
        CNT_SPLIT,
        CNT_WRAP,
        CNT_RANDOM,
        CNT_ZERO
    } count_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;

    int src_idle_pct  = 29;
    int sink_idle_pct = 29;
    bit stall_req     = 1'b0;
    int words_sent    = 0;
    int cycle_count   = 0;

    // settings the stream is framed for
    logic [15:0] cur_max = MAX_LENGTH_RESET;
    logic        cur_be  = 1'b1;
    logic [7:0]  frame [$];

    always #2 aclk = ~aclk;

    archive_packet_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    archive_packet_deframer_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic push_word(logic [7:0] b, logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, stream_end: e};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // drop valid and wait until every result word has been taken
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || m_valid) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [15:0] mx, logic be);
        write_reg(CFG_MAX_LENGTH, mx);
        write_reg(CFG_BIG_ENDIAN, {15'd0, be});
        cur_max = mx;
        cur_be  = be;
    endtask

    function automatic void put_multi(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            frame.push_back(v[8 * (cur_be ? n - 1 - i : i) +: 8]);
    endfunction

    function automatic void build_frame(logic [31:0] ids, logic [15:0] len,
                                        logic [31:0] otime, count_mode_t cm, bit hash_tail);
        logic [15:0] cnt;
        logic [15:0] left;
        bit          all_hash;
        frame.delete();
        for (int i = 0; i < 4; i++)
            frame.push_back(ids[31 - 8 * i -: 8]);
        put_multi(32'(len), 2);
        put_multi(otime, 4);
        left = len;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            case (cm)
                CNT_SPLIT: begin
                    cnt = (c == NUM_CHANNELS - 1) ? left : 16'($urandom_range(left / 4 + 1));
                    if (cnt > left)
                        cnt = left;
                end
                CNT_WRAP: begin
                    // arbitrary counts, last one closes the sum modulo 2^16
                    cnt = (c == NUM_CHANNELS - 1) ? left : 16'($urandom);
                end
                CNT_RANDOM: cnt = 16'($urandom_range(9));
                default:    cnt = 16'd0;
            endcase
            left = left - cnt;
            put_multi(32'(cnt), 2);
        end
        for (int i = 0; i < int'(len); i++)
            frame.push_back(8'($urandom));
        all_hash = 1'b1;
        for (int i = 0; i < TRAILER_BYTES; i++) begin
            frame.push_back((hash_tail || $urandom_range(1)) ? HASH_CHAR : 8'($urandom));
            if (frame[$] != HASH_CHAR)
                all_hash = 1'b0;
        end
        if (!hash_tail && all_hash)
            frame[frame.size() - 1 - $urandom_range(TRAILER_BYTES - 1)] = HASH_CHAR + 8'd1;
    endfunction

    // send the frame; a non-negative cut ends the stream on that byte
    task automatic send_frame(int cut);
        for (int i = 0; i < frame.size(); i++) begin
            push_word(frame[i], i == cut);
            if (i == cut)
                break;
        end
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (cur_max <= 16'd300 && r < 10)
            return cur_max + 16'($urandom_range(1));
        if (r < 88)
            return 16'($urandom_range(40));
        return 16'($urandom_range(300, 41));
    endfunction

    task automatic random_sequence();
        int          r;
        int          n;
        int          cut;
        count_mode_t cm;
        r   = $urandom_range(99);
        cut = -1;
        if (r >= 93) begin
            // noise, closed by an end of stream to resynchronise
            n = $urandom_range(12, 1);
            for (int i = 0; i < n; i++)
                push_word(8'($urandom), i == n - 1);
        end else begin
            cm = $urandom_range(1) ? CNT_SPLIT : CNT_WRAP;
            if (r >= 85)
                cm = $urandom_range(1) ? CNT_RANDOM : CNT_ZERO;
            build_frame($urandom, pick_length(), $urandom, cm, $urandom_range(99) < 80);
            if (r >= 70 && r < 85)
                cut = $urandom_range(frame.size() - 1);
            send_frame(cut);
        end
    endtask

    task automatic run_phase(logic [15:0] mx, logic be, int n_words, bit hold_sink);
        int stop_at;
        settle();
        set_config(mx, be);
        // hold off the result side while the stream keeps coming
        if (hold_sink)
            stall_req = 1'b1;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
            random_sequence();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MAX_LENGTH;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // header extremes, empty body, '#' trailer
        build_frame(32'hFF00FF00, 16'd0, 32'hFFFF_FFFF, CNT_ZERO, 1'b1);
        send_frame(-1);
        build_frame(32'h00FF00FF, 16'd5, 32'h0, CNT_SPLIT, 1'b0);
        send_frame(-1);
        // random channel counts, so the sum almost never matches the length
        build_frame($urandom, 16'd6, $urandom, CNT_RANDOM, 1'b1);
        send_frame(-1);
        // cut short on the first byte, mid-header, on the last header byte,
        // mid-body, and exactly on the final trailer byte
        build_frame($urandom, 16'd8, $urandom, CNT_SPLIT, 1'b1);
        send_frame(0);
        send_frame(7);
        send_frame(HEADER_BYTES - 1);
        send_frame(HEADER_BYTES + 2);
        send_frame(frame.size() - 1);
        // longest length with nothing summed: payload lands beyond every channel
        build_frame($urandom, 16'hFFFF, $urandom, CNT_ZERO, 1'b0);
        send_frame(HEADER_BYTES + 3);
        // length over the limit
        settle();
        set_config(16'd4, 1'b1);
        build_frame($urandom, 16'd5, $urandom, CNT_SPLIT, 1'b1);
        send_frame(-1);
        // flip byte order in the middle of the body, then end the stream
        build_frame($urandom, 16'd3, $urandom, CNT_SPLIT, 1'b1);
        for (int i = 0; i <= HEADER_BYTES; i++)
            push_word(frame[i], 1'b0);
        settle();
        write_reg(CFG_BIG_ENDIAN, 16'd0);
        cur_be = 1'b0;
        for (int i = 0; i < 3; i++)
            push_word(8'($urandom), i == 2);

        run_phase(MAX_LENGTH_RESET, 1'b1, PHASE_WORDS, 1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(16'd0, 1'b0, PHASE_WORDS, 1'b0);
        src_idle_pct  = 29;
        sink_idle_pct = 29;
        run_phase(16'hFFFF, 1'b0, PHASE_WORDS, 1'b1);
        run_phase(16'd20, 1'b1, PHASE_WORDS, 1'b0);
        run_phase(16'($urandom), 1'($urandom), PHASE_WORDS, 1'b0);

        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
